### src/dfpu_pkg.sv
// shared types, codes and constants of the double floating-point unit
// no dependencies
package dfpu_pkg;

  localparam int FW = 51;   // working significand width, hidden bit at the top
  localparam int EW = 15;   // signed working exponent width

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  localparam logic [1:0] T_ZRO = 2'd0;
  localparam logic [1:0] T_INF = 2'd1;
  localparam logic [1:0] T_NAN = 2'd2;
  localparam logic [1:0] T_NUM = 2'd3;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;
  localparam logic [1:0] CMP_UN = 2'd3;

  localparam logic [2:0] KIND_DONE = 3'd0;
  localparam logic [2:0] KIND_PACK = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;

  localparam logic signed [EW-1:0] MUL_BIAS = 15'sd2045;
  localparam logic signed [EW-1:0] DIV_BIAS = 15'sd4093;
  localparam logic signed [EW-1:0] EXP_MAX  = 15'sd4093;
  localparam logic signed [EW-1:0] SUB_MIN  = -15'sd50;
  localparam logic signed [EW-1:0] ALIGN_MAX = 15'sd60;

  localparam logic [11:0] EXP_ALL  = 12'hFFF;
  localparam logic [59:0] MAG_INF  = 60'hFFF_0000_0000_0000;
  localparam logic [59:0] MAG_QNAN = 60'hFFF_8000_0000_0000;
  localparam int          QBIT     = 49;

  localparam logic [5:0] STEP_LAST = 6'd50;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [62:0] operand_a;
    logic [62:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [62:0] result_value;
    logic [1:0]  compare_outcome;
    logic        overflow_raised;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic setup;
    logic align;
    logic addsub;
    logic lnorm;
    logic mstep;
    logic dstep;
    logic fix;
    logic pack;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       norm_done;
    logic       lnorm_done;
    logic [2:0] kind;
  } sts_t;

endpackage

### src/dfpu_if.sv
// request and response channel interfaces
// depends on dfpu_pkg
interface dfpu_req_if import dfpu_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dfpu_rsp_if import dfpu_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/dfpu_dp.sv
// datapath: operand unpack, add/mul/div iteration, rounding and result registers
// depends on dfpu_pkg
module dfpu_dp import dfpu_pkg::*; (
  input  logic        clk,
  input  req_t        req_in,
  input  cmd_t        cmd,
  output sts_t        sts,
  output rsp_t        rsp_out
);

  function automatic logic [1:0] kind_of(logic [62:0] x);
    logic [11:0] ee;
    logic [47:0] fr;
    ee = x[61:50];
    fr = {x[49:32], x[29:0]};
    if (ee == 12'd0) return (fr == '0) ? T_ZRO : T_NUM;
    if (ee == EXP_ALL) return (fr == '0) ? T_INF : T_NAN;
    return T_NUM;
  endfunction

  function automatic logic [62:0] enc(logic s, logic [59:0] mag);
    return {s, mag[59:30], 1'b0, s, mag[29:0]};
  endfunction

  logic [1:0]           op;
  logic [62:0]          a_raw, b_raw;
  logic                 ys, zs, xs, sub;
  logic [1:0]           yt, zt;
  logic [FW-1:0]        yf, zf, pf;
  logic signed [EW-1:0] ye, ze, xe, pe;
  logic [54:0]          acc;
  logic [51:0]          q;
  logic                 stk;
  logic [62:0]          fin_val;
  logic [1:0]           fin_cmp;
  logic                 fin_ov;

  // setup decision
  logic [2:0]  sp_kind;
  logic [62:0] sp_val;
  logic [1:0]  sp_cmp;
  logic        sp_ov;
  logic        pick_z, swap, y_less, div_ge;
  logic [FW-1:0] div_rem0;

  always_comb begin
    sp_kind = KIND_DONE;
    sp_val  = '0;
    sp_cmp  = CMP_LT;
    sp_ov   = 1'b0;
    pick_z  = (yt == T_ZRO);
    y_less  = (ye < ze) || (ye == ze && yf < zf);
    swap    = y_less;
    div_ge  = (yf >= zf);
    div_rem0 = div_ge ? (yf - zf) : yf;
    if (op != OP_CMP && (yt == T_NAN || zt == T_NAN)) begin
      if (zt == T_NAN) begin
        sp_ov  = (yt == T_NAN && !a_raw[QBIT]) || !b_raw[QBIT];
        sp_val = b_raw | (63'd1 << QBIT);
      end else begin
        sp_ov  = !a_raw[QBIT];
        sp_val = a_raw | (63'd1 << QBIT);
      end
    end else begin
      case (op)
        OP_ADD: begin
          if ((yt == T_ZRO && zt == T_NUM) || (yt == T_NUM && zt == T_ZRO)) begin
            sp_kind = KIND_PACK;
          end else if (yt == T_INF && zt == T_INF && ys != zs) begin
            sp_ov  = 1'b1;
            sp_val = enc(zs, MAG_QNAN);
          end else if (zt == T_INF) begin
            sp_val = enc(zs, MAG_INF);
          end else if (yt == T_INF) begin
            sp_val = enc(ys, MAG_INF);
          end else if (yt == T_ZRO) begin
            sp_val = enc(ys && zs, '0);
          end else if (ye == ze && yf == zf && ys != zs) begin
            sp_val = '0;
          end else begin
            sp_kind = KIND_ADD;
          end
        end
        OP_MUL: begin
          if ((yt == T_ZRO && zt == T_INF) || (yt == T_INF && zt == T_ZRO)) begin
            sp_val = enc(ys ^ zs, MAG_QNAN);
          end else if (yt == T_INF || zt == T_INF) begin
            sp_val = enc(ys ^ zs, MAG_INF);
          end else if (yt == T_ZRO || zt == T_ZRO) begin
            sp_val = enc(ys ^ zs, '0);
          end else begin
            sp_kind = KIND_MUL;
          end
        end
        OP_DIV: begin
          if ((yt == T_ZRO && zt == T_ZRO) || (yt == T_INF && zt == T_INF)) begin
            sp_val = enc(ys ^ zs, MAG_QNAN);
          end else if (yt == T_ZRO || zt == T_INF) begin
            sp_val = enc(ys ^ zs, '0);
          end else if (yt == T_INF || zt == T_ZRO) begin
            sp_ov  = (yt == T_NUM);
            sp_val = enc(ys ^ zs, MAG_INF);
          end else begin
            sp_kind = KIND_DIV;
          end
        end
        default: begin
          if (yt == T_NAN || zt == T_NAN) sp_cmp = CMP_UN;
          else if (yt == T_ZRO && zt == T_ZRO) sp_cmp = CMP_EQ;
          else if (yt == T_ZRO) sp_cmp = zs ? CMP_GT : CMP_LT;
          else if (zt == T_ZRO) sp_cmp = ys ? CMP_LT : CMP_GT;
          else if (ys != zs) sp_cmp = ys ? CMP_LT : CMP_GT;
          else if (yt == T_INF && zt == T_INF) sp_cmp = CMP_EQ;
          else if (yt == T_INF) sp_cmp = ys ? CMP_LT : CMP_GT;
          else if (zt == T_INF) sp_cmp = zs ? CMP_GT : CMP_LT;
          else if (ye == ze && yf == zf) sp_cmp = CMP_EQ;
          else sp_cmp = (ys != y_less) ? CMP_LT : CMP_GT;
        end
      endcase
    end
  end

  // alignment of the smaller addend
  logic signed [EW-1:0] al_d;
  logic [5:0]           al_sh;
  logic [53:0]          al_z, al_shr;
  always_comb begin
    al_d   = ye - ze;
    al_sh  = al_d[5:0];
    al_z   = {zf, 3'b000};
    al_shr = al_z >> al_sh;
  end

  // add or subtract
  logic [54:0] as_r;
  assign as_r = sub ? ({1'b0, yf, 3'b000} - acc) : ({1'b0, yf, 3'b000} + acc);

  // multiply step and divide step
  logic [51:0] ms_sum, ds_r2;
  logic        ds_ge;
  assign ms_sum = {1'b0, acc[50:0]} + (zf[0] ? {1'b0, yf} : 52'd0);
  assign ds_r2  = {acc[50:0], 1'b0};
  assign ds_ge  = ds_r2 >= {1'b0, zf};

  // rounding and packing
  logic [FW-1:0] pk_o;
  logic [11:0]   pk_e;
  logic [5:0]    pk_sh;
  logic [FW-1:0] pk_shr;
  logic [51:0]   pk_rnd;
  logic [60:0]   pk_mag;
  logic signed [EW-1:0] pk_neg;
  always_comb begin
    pk_neg = -pe;
    pk_sh  = pk_neg[5:0];
    pk_shr = pf >> pk_sh;
    if (pe > EXP_MAX) begin
      pk_o = '0;
      pk_e = EXP_ALL;
    end else if (pe < 15'sd0) begin
      pk_e = '0;
      if (pe < SUB_MIN) pk_o = FW'(1);
      else pk_o = pk_shr | FW'((pk_shr << pk_sh) != pf);
    end else begin
      pk_o = pf;
      pk_e = pe[11:0];
    end
    pk_rnd = {1'b0, pk_o} + (pk_o[2] ? 52'd2 : 52'd1);
    pk_mag = {1'b0, pk_e, 48'd0} + {11'd0, pk_rnd[51:2]};
  end

  assign sts.norm_done  = (yf == '0 || yf[FW-1]) && (zf == '0 || zf[FW-1]);
  assign sts.lnorm_done = (acc == '0) || acc[53];
  assign sts.kind       = sp_kind;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req_in.req_type;
      a_raw <= req_in.operand_a;
      b_raw <= req_in.operand_b;
      ys    <= req_in.operand_a[62];
      zs    <= req_in.operand_b[62];
      yt    <= kind_of(req_in.operand_a);
      zt    <= kind_of(req_in.operand_b);
      yf    <= {req_in.operand_a[61:50] != 12'd0, req_in.operand_a[49:32],
                req_in.operand_a[29:0], 2'b00};
      zf    <= {req_in.operand_b[61:50] != 12'd0, req_in.operand_b[49:32],
                req_in.operand_b[29:0], 2'b00};
      ye    <= (req_in.operand_a[61:50] != 12'd0) ?
               $signed({3'b000, req_in.operand_a[61:50] - 12'd1}) : '0;
      ze    <= (req_in.operand_b[61:50] != 12'd0) ?
               $signed({3'b000, req_in.operand_b[61:50] - 12'd1}) : '0;
    end
    if (cmd.norm) begin
      if (yf != '0 && !yf[FW-1]) begin
        yf <= yf << 1;
        ye <= ye - 15'sd1;
      end
      if (zf != '0 && !zf[FW-1]) begin
        zf <= zf << 1;
        ze <= ze - 15'sd1;
      end
    end
    if (cmd.setup) begin
      fin_val <= sp_val;
      fin_cmp <= sp_cmp;
      fin_ov  <= sp_ov;
      stk     <= 1'b0;
      sub     <= ys != zs;
      case (sp_kind)
        KIND_PACK: begin
          pf <= pick_z ? zf : yf;
          pe <= pick_z ? ze : ye;
          xs <= pick_z ? zs : ys;
        end
        KIND_ADD: begin
          if (swap) begin
            yf <= zf;
            zf <= yf;
            ye <= ze;
            ze <= ye;
          end
          xs <= swap ? zs : ys;
          xe <= swap ? ze : ye;
        end
        KIND_MUL: begin
          acc <= '0;
          xs  <= ys ^ zs;
          xe  <= ye + ze - MUL_BIAS;
        end
        KIND_DIV: begin
          acc <= {4'd0, div_rem0};
          q   <= {51'd0, div_ge};
          xs  <= ys ^ zs;
          xe  <= ye - ze + DIV_BIAS;
        end
        default: ;
      endcase
    end
    if (cmd.align) begin
      if (al_d >= ALIGN_MAX) acc <= 55'd1;
      else acc <= {1'b0, al_shr | 54'((al_shr << al_sh) != al_z)};
    end
    if (cmd.addsub) begin
      if (as_r[54]) begin
        acc <= {1'b0, as_r[54:1]} | {54'd0, as_r[0]};
        xe  <= xe + 15'sd1;
      end else begin
        acc <= as_r;
      end
    end
    if (cmd.lnorm) begin
      if (acc != '0 && !acc[53]) begin
        acc <= acc << 1;
        xe  <= xe - 15'sd1;
      end
    end
    if (cmd.mstep) begin
      acc <= {4'd0, ms_sum[51:1]};
      stk <= stk | ms_sum[0];
      zf  <= zf >> 1;
    end
    if (cmd.dstep) begin
      acc <= {3'd0, ds_ge ? (ds_r2 - {1'b0, zf}) : ds_r2};
      q   <= {q[50:0], ds_ge};
    end
    if (cmd.fix) begin
      case (op)
        OP_MUL: begin
          if (acc[50]) begin
            pf <= acc[50:0] | FW'(stk);
            pe <= xe;
          end else begin
            pf <= {acc[49:0], 1'b0} | FW'(stk);
            pe <= xe - 15'sd1;
          end
        end
        OP_DIV: begin
          if (q[51]) begin
            pf <= q[51:1] | FW'((acc[51:0] != '0) || q[0]);
            pe <= xe + 15'sd1;
          end else begin
            pf <= q[50:0] | FW'(acc[51:0] != '0);
            pe <= xe;
          end
        end
        default: begin
          pf <= acc[53:3] | FW'(acc[2:0] != 3'd0);
          pe <= xe;
        end
      endcase
    end
    if (cmd.pack) begin
      fin_val <= enc(xs, pk_mag[59:0]);
      fin_cmp <= CMP_LT;
      fin_ov  <= pk_mag >= {1'b0, EXP_ALL, 48'd0};
    end
    if (cmd.emit) begin
      rsp_out.result_value    <= fin_val;
      rsp_out.compare_outcome <= fin_cmp;
      rsp_out.overflow_raised <= fin_ov;
    end
  end

endmodule

### src/dfpu_ctrl.sv
// controller: sequences the datapath through one operation and owns the handshakes
// depends on dfpu_pkg
module dfpu_ctrl import dfpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NORM   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_ALIGN  = 4'd3;
  localparam logic [3:0] S_ADDSUB = 4'd4;
  localparam logic [3:0] S_LNORM  = 4'd5;
  localparam logic [3:0] S_MSTEP  = 4'd6;
  localparam logic [3:0] S_DSTEP  = 4'd7;
  localparam logic [3:0] S_FIX    = 4'd8;
  localparam logic [3:0] S_PACK   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (sts.norm_done) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        cnt_next  = '0;
        unique case (sts.kind)
          KIND_PACK: state_next = S_PACK;
          KIND_ADD:  state_next = S_ALIGN;
          KIND_MUL:  state_next = S_MSTEP;
          KIND_DIV:  state_next = S_DSTEP;
          default:   state_next = S_DONE;
        endcase
      end
      S_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = S_ADDSUB;
      end
      S_ADDSUB: begin
        cmd.addsub = 1'b1;
        state_next = S_LNORM;
      end
      S_LNORM: begin
        cmd.lnorm = 1'b1;
        if (sts.lnorm_done) state_next = S_FIX;
      end
      S_MSTEP: begin
        cmd.mstep = 1'b1;
        cnt_next  = cnt + 6'd1;
        if (cnt == STEP_LAST) state_next = S_FIX;
      end
      S_DSTEP: begin
        cmd.dstep = 1'b1;
        cnt_next  = cnt + 6'd1;
        if (cnt == STEP_LAST) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_PACK;
      end
      S_PACK: begin
        cmd.pack   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### src/mix_double_float_arith_unit.sv
// channel    dir  payload
// req        in   req_type, operand_a, operand_b
// rsp        out  result_value, compare_outcome, overflow_raised
//
// one operation at a time: accept, operand normalize (repeated for subnormals), setup,
// then nothing more for special operands and compare, pack for zero plus number,
// align, add, left normalize, fix and pack for add, and the 51-step shift-add and
// restoring loops, fix and pack for multiply and divide, then the output register
// rst is synchronous and clears the controller and the output valid
// a held result does not block the next request; the block waits only if a new
// result is ready while the output register is still full
// depends on dfpu_pkg, dfpu_if, dfpu_ctrl, dfpu_dp
module mix_double_float_arith_unit import dfpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  dfpu_req_if.sink   req,
  dfpu_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_reg;

  dfpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dfpu_dp u_dp (
    .clk     (clk),
    .req_in  (req.payload),
    .cmd     (cmd),
    .sts     (sts),
    .rsp_out (rsp_reg)
  );

  assign rsp.payload = rsp_reg;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an operation is in progress");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.compare_outcome != CMP_LT |->
      rsp.payload.result_value == '0 && !rsp.payload.overflow_raised)
    else $error("compare result carries a value or overflow");

  a_rst_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");

endmodule

### verif/dfpu_scoreboard.sv
// scoreboard for the double floating-point unit: bit-exact result prediction and checking
// depends on dfpu_pkg
`timescale 1ns / 1ps

class dfpu_scoreboard;
  dfpu_pkg::rsp_t pending[$];
  int mismatches;
  int checked;

  localparam logic [1:0] K_ZRO = dfpu_pkg::T_ZRO;
  localparam logic [1:0] K_INF = dfpu_pkg::T_INF;
  localparam logic [1:0] K_NAN = dfpu_pkg::T_NAN;
  localparam logic [1:0] K_NUM = dfpu_pkg::T_NUM;

  function new();
    mismatches = 0;
    checked = 0;
  endfunction

  static function logic [62:0] enc(bit s, logic [59:0] mag);
    logic [62:0] w;
    w = {1'b0, mag[59:30], 2'b00, mag[29:0]};
    if (s) begin
      w[62] = 1'b1;
      w[30] = 1'b1;
    end
    return w;
  endfunction

  static function logic [1:0] decode(logic [62:0] x, output logic [63:0] f,
                                     output int e, output bit s);
    logic [59:0] mag;
    logic [47:0] fr;
    int ee;
    mag = {x[61:32], x[29:0]};
    fr = mag[47:0];
    ee = int'(mag[59:48]);
    s = x[62];
    f = {14'd0, fr, 2'b00};
    if (ee != 0) begin
      e = ee - 1;
      f[50] = 1'b1;
      if (ee < 4095) return K_NUM;
      return (fr == 0) ? K_INF : K_NAN;
    end
    e = 0;
    if (f == 0) return K_ZRO;
    while (f[50] == 1'b0) begin
      ee--;
      f = f << 1;
    end
    e = ee;
    return K_NUM;
  endfunction

  static function logic [62:0] round_pack(logic [63:0] f, int e, bit s, inout bit ov);
    logic [63:0] o;
    int sh;
    if (e > 4093) begin
      e = 4095;
      o = 64'd0;
    end else if (e < 0) begin
      if (e < -50) o = 64'd1;
      else begin
        sh = -e;
        o = f >> sh;
        if ((o << sh) != f) o[0] = 1'b1;
      end
      e = 0;
    end else o = f;
    o = o + (o[2] ? 64'd2 : 64'd1);
    o = o >> 2;
    o = o + (64'(e) << 48);
    if (o >= (64'hFFF << 48)) ov = 1;
    return enc(s, o[59:0]);
  endfunction

  static function bit nan_pick(logic [1:0] yt, logic [1:0] zt, logic [62:0] y,
                               logic [62:0] z, output logic [62:0] r, inout bit ov);
    if (zt == K_NAN) begin
      if (yt == K_NAN && !y[49]) ov = 1;
      if (!z[49]) ov = 1;
      r = z;
      r[49] = 1'b1;
      return 1;
    end
    if (yt == K_NAN) begin
      if (!y[49]) ov = 1;
      r = y;
      r[49] = 1'b1;
      return 1;
    end
    return 0;
  endfunction

  static function logic [62:0] sum(logic [62:0] y, logic [62:0] z, inout bit ov);
    logic [63:0] yf, zf, t, ya, za, rr, lost;
    int ye, ze, it, d, xe;
    bit ys, zs, bs;
    logic [1:0] yt, zt;
    logic [62:0] r;
    yt = decode(y, yf, ye, ys);
    zt = decode(z, zf, ze, zs);
    if (nan_pick(yt, zt, y, z, r, ov)) return r;
    if (yt == K_ZRO && zt == K_NUM) return round_pack(zf, ze, zs, ov);
    if (yt == K_NUM && zt == K_ZRO) return round_pack(yf, ye, ys, ov);
    if (yt == K_INF && zt == K_INF && ys != zs) begin
      ov = 1;
      return enc(zs, dfpu_pkg::MAG_QNAN);
    end
    if (zt == K_INF) return enc(zs, dfpu_pkg::MAG_INF);
    if (yt == K_INF) return enc(ys, dfpu_pkg::MAG_INF);
    if (yt == K_ZRO) return enc(ys && zs, 60'd0);
    if (ye == ze && yf == zf && ys != zs) return 63'd0;
    if (ye < ze || (ye == ze && yf < zf)) begin
      t = yf; yf = zf; zf = t;
      it = ye; ye = ze; ze = it;
      bs = ys; ys = zs; zs = bs;
    end
    d = ye - ze;
    ya = yf << 3;
    za = zf << 3;
    xe = ye;
    if (d >= 60) za = 64'd1;
    else if (d > 0) begin
      lost = za & ((64'd1 << d) - 64'd1);
      za = za >> d;
      if (lost != 0) za[0] = 1'b1;
    end
    rr = (ys != zs) ? ya - za : ya + za;
    if (rr >= (64'd1 << 54)) begin
      rr = (rr >> 1) | (rr & 64'd1);
      xe++;
    end
    while (rr != 0 && rr < (64'd1 << 53)) begin
      rr = rr << 1;
      xe--;
    end
    return round_pack((rr >> 3) | ((rr[2:0] != 0) ? 64'd1 : 64'd0), xe, ys, ov);
  endfunction

  static function logic [62:0] product(logic [62:0] y, logic [62:0] z, inout bit ov);
    logic [63:0] yf, zf, xf, top;
    logic [127:0] p;
    int ye, ze, xe;
    bit ys, zs, xs;
    logic [1:0] yt, zt;
    logic [62:0] r;
    yt = decode(y, yf, ye, ys);
    zt = decode(z, zf, ze, zs);
    if (nan_pick(yt, zt, y, z, r, ov)) return r;
    xs = ys != zs;
    if ((yt == K_ZRO && zt == K_INF) || (yt == K_INF && zt == K_ZRO))
      return enc(xs, dfpu_pkg::MAG_QNAN);
    if (yt == K_INF || zt == K_INF) return enc(xs, dfpu_pkg::MAG_INF);
    if (yt == K_ZRO || zt == K_ZRO) return enc(xs, 60'd0);
    p = {64'd0, yf} * {64'd0, zf};
    top = p[114:51];
    xe = ye + ze - 2045;
    if (top >= (64'd1 << 50)) xf = top;
    else begin
      xf = top << 1;
      xe--;
    end
    if (p[50:0] != 0) xf[0] = 1'b1;
    return round_pack(xf, xe, xs, ov);
  endfunction

  static function logic [62:0] quotient(logic [62:0] y, logic [62:0] z, inout bit ov);
    logic [63:0] yf, zf, q, rem;
    int ye, ze, xe;
    bit ys, zs, xs, st;
    logic [1:0] yt, zt;
    logic [62:0] r;
    yt = decode(y, yf, ye, ys);
    zt = decode(z, zf, ze, zs);
    if (nan_pick(yt, zt, y, z, r, ov)) return r;
    xs = ys != zs;
    if ((yt == K_ZRO && zt == K_ZRO) || (yt == K_INF && zt == K_INF))
      return enc(xs, dfpu_pkg::MAG_QNAN);
    if (yt == K_ZRO || zt == K_INF) return enc(xs, 60'd0);
    if (yt == K_NUM && zt == K_ZRO) ov = 1;
    if (yt == K_INF || zt == K_ZRO) return enc(xs, dfpu_pkg::MAG_INF);
    q = 64'd0;
    rem = yf;
    xe = ye - ze + 4093;
    if (rem >= zf) begin
      q = 64'd1;
      rem = rem - zf;
    end
    for (int i = 0; i < 51; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= zf) begin
        rem = rem - zf;
        q[0] = 1'b1;
      end
    end
    st = rem != 0;
    if (q >= (64'd1 << 51)) begin
      if (q[0]) st = 1;
      q = q >> 1;
      xe++;
    end
    if (st) q[0] = 1'b1;
    return round_pack(q, xe, xs, ov);
  endfunction

  static function logic [1:0] order(logic [62:0] y, logic [62:0] z);
    logic [63:0] yf, zf;
    int ye, ze;
    bit ys, zs, less;
    logic [1:0] yt, zt;
    yt = decode(y, yf, ye, ys);
    zt = decode(z, zf, ze, zs);
    if (yt == K_NAN || zt == K_NAN) return dfpu_pkg::CMP_UN;
    if (yt == K_ZRO && zt == K_ZRO) return dfpu_pkg::CMP_EQ;
    if (yt == K_ZRO) return zs ? dfpu_pkg::CMP_GT : dfpu_pkg::CMP_LT;
    if (zt == K_ZRO) return ys ? dfpu_pkg::CMP_LT : dfpu_pkg::CMP_GT;
    if (ys != zs) return ys ? dfpu_pkg::CMP_LT : dfpu_pkg::CMP_GT;
    if (yt == K_INF && zt == K_INF) return dfpu_pkg::CMP_EQ;
    if (yt == K_INF) return ys ? dfpu_pkg::CMP_LT : dfpu_pkg::CMP_GT;
    if (zt == K_INF) return zs ? dfpu_pkg::CMP_GT : dfpu_pkg::CMP_LT;
    if (ye == ze && yf == zf) return dfpu_pkg::CMP_EQ;
    less = ye < ze || (ye == ze && yf < zf);
    return (ys != less) ? dfpu_pkg::CMP_LT : dfpu_pkg::CMP_GT;
  endfunction

  function void note_request(dfpu_pkg::req_t q);
    dfpu_pkg::rsp_t e;
    bit ov;
    ov = 0;
    e = '0;
    case (q.req_type)
      dfpu_pkg::OP_ADD: e.result_value = sum(q.operand_a, q.operand_b, ov);
      dfpu_pkg::OP_MUL: e.result_value = product(q.operand_a, q.operand_b, ov);
      dfpu_pkg::OP_DIV: e.result_value = quotient(q.operand_a, q.operand_b, ov);
      default: e.compare_outcome = order(q.operand_a, q.operand_b);
    endcase
    e.overflow_raised = ov;
    pending.push_back(e);
  endfunction

  function void check_result(dfpu_pkg::rsp_t got);
    dfpu_pkg::rsp_t e;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    e = pending.pop_front();
    if (got.result_value !== e.result_value || got.compare_outcome !== e.compare_outcome
        || got.overflow_raised !== e.overflow_raised) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected val=%h cmp=%0d ov=%0b, got val=%h cmp=%0d ov=%0b",
                 checked, e.result_value, e.compare_outcome, e.overflow_raised,
                 got.result_value, got.compare_outcome, got.overflow_raised);
    end
  endfunction
endclass

### verif/mix_double_float_arith_unit_tb.sv
// testbench top: directed and random requests through the double floating-point unit
// depends on dfpu_pkg, dfpu_if, dfpu_scoreboard.sv and the unit rtl
`timescale 1ns / 1ps

module mix_double_float_arith_unit_tb;
  import dfpu_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int sent;

  dfpu_req_if req ();
  dfpu_rsp_if rsp ();

  dfpu_scoreboard sb;

  mix_double_float_arith_unit u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    rst = 1;
    req.valid = 0;
    req.payload = '0;
    rsp.ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
  initial cycles = 0;

  // receive side: random stall, check every accepted beat
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.payload);
    if (rst) rsp.ready <= 0;
    else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [62:0] mk(bit s, logic [11:0] ex, logic [47:0] fr);
    logic [59:0] mag;
    logic [62:0] w;
    mag = {ex, fr};
    w = {1'b0, mag[59:30], 2'b00, mag[29:0]};
    if (s) begin
      w[62] = 1;
      w[30] = 1;
    end
    return w;
  endfunction

  // mostly well-formed doubles, exponents clustered so results stay interesting
  function automatic logic [62:0] rand_double();
    logic [62:0] w;
    logic [11:0] ex;
    logic [47:0] fr;
    int k;
    k = $urandom_range(99);
    fr = 48'({$urandom, $urandom});
    if (k < 8) return 63'({$urandom, $urandom});
    if (k < 14) ex = 12'd0;
    else if (k < 20) ex = 12'hFFF;
    else if (k < 26) ex = 12'($urandom_range(4095));
    else if (k < 32) ex = 12'($urandom_range(1, 40));
    else if (k < 38) ex = 12'($urandom_range(4060, 4094));
    else ex = 12'($urandom_range(1980, 2110));
    if (k >= 14 && k < 20 && $urandom_range(1)) fr = 48'd0;
    if ($urandom_range(9) == 0) fr = fr >> $urandom_range(47);
    w = mk(1'($urandom_range(1)), ex, fr);
    if ($urandom_range(15) == 0) w[31] = 1'($urandom_range(1));
    if ($urandom_range(15) == 0) w[30] = 1'($urandom_range(1));
    return w;
  endfunction

  // valid stays high into the next beat unless the sender idles
  task automatic send(logic [1:0] op, logic [62:0] a, logic [62:0] b);
    req_t q;
    q.req_type = op;
    q.operand_a = a;
    q.operand_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.payload <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(q);
    sent++;
  endtask

  task automatic send_all_ops(logic [62:0] a, logic [62:0] b);
    send(OP_ADD, a, b);
    send(OP_MUL, a, b);
    send(OP_DIV, a, b);
    send(OP_CMP, a, b);
  endtask

  initial begin
    logic [62:0] a, b, one, inf, snan, qnan, tiny, big;
    int r;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    one = mk(1'b0, 12'd2047, 48'd0);
    inf = mk(1'b0, 12'hFFF, 48'd0);
    snan = mk(1'b0, 12'hFFF, 48'd5);
    qnan = mk(1'b1, 12'hFFF, 48'h8000_0000_0001);
    tiny = mk(1'b0, 12'd0, 48'd1);
    big = mk(1'b0, 12'd4094, 48'hFFFF_FFFF_FFFF);
    // special cases
    send_all_ops(63'd0, mk(1'b1, 12'd0, 48'd0));
    send_all_ops(mk(1'b1, 12'd0, 48'd0), mk(1'b1, 12'd0, 48'd0));
    send_all_ops(one, one | (63'd1 << 62) | (63'd1 << 30));
    send_all_ops(inf, inf | (63'd1 << 62) | (63'd1 << 30));
    send_all_ops(63'd0, inf);
    send(OP_DIV, one, 63'd0);
    send(OP_DIV, inf, 63'd0);
    send(OP_ADD, snan, qnan);
    send(OP_MUL, qnan, snan);
    send(OP_ADD, snan, one);
    send(OP_MUL, big, big);
    send(OP_ADD, big, big);
    send(OP_MUL, tiny, tiny);
    send(OP_DIV, tiny, big);
    send(OP_DIV, big, tiny);
    send(OP_CMP, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0);
    send(OP_ADD, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    send(OP_ADD, tiny, one);
    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 240; i++) begin
        a = rand_double();
        r = $urandom_range(99);
        if (r < 15) b = a ^ (63'd1 << 62);
        else if (r < 25) b = a ^ (63'd1 << $urandom_range(20));
        else b = rand_double();
        send(2'($urandom_range(3)), a, b);
      end
    end
    req.valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests (all four operations, specials, subnormals, random stalls)",
             sent);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### filelist.f
src/dfpu_pkg.sv
src/dfpu_if.sv
src/dfpu_dp.sv
src/dfpu_ctrl.sv
src/mix_double_float_arith_unit.sv
verif/dfpu_scoreboard.sv
verif/mix_double_float_arith_unit_tb.sv
